FILE: hdl/odrc_pkg.sv
// ----------------------------------------------------------------------------
// odrc_pkg: shared types and constants of the divider / RFREQ calculator
// Holds the register indexes, the status codes, the sequencer states and the
// bus struct that the sequencer hands to the serial divider.
// ----------------------------------------------------------------------------
package odrc_pkg;

  localparam int FREQ_W  = 32;
  localparam int RFREQ_W = 38;
  localparam int CFG_W   = 32;
  localparam int PROD_W  = 43;   // total divider (11) times frequency (32)
  localparam int DIVQ_W  = 72;   // quotient bits, one per step
  localparam int DIV_STEPS = 72;
  localparam int DIV_IN_BITS = 40;
  localparam logic [10:0] DIV_START = 11'd1408;
  localparam logic [RFREQ_W-1:0] RFREQ_MAX = {RFREQ_W{1'b1}};

  typedef enum logic [2:0] {
    REG_CRYSTAL = 3'd0,
    REG_DCO_MIN = 3'd1,
    REG_DCO_MAX = 3'd2,
    REG_GRADE   = 3'd3,
    REG_PPM     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_FAIL  = 2'd0,
    ST_SMALL = 2'd1,
    ST_LARGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_N0, S_SEARCH, S_HSDIV, S_PROD, S_RFREQ, S_WAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] prod;
    logic [31:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVQ_W-1:0] quo;
  } div_rsp_t;

  function automatic logic [3:0] hs_at(input logic [2:0] i);
    case (i)
      3'd0:    hs_at = 4'd11;
      3'd1:    hs_at = 4'd9;
      3'd2:    hs_at = 4'd7;
      3'd3:    hs_at = 4'd6;
      3'd4:    hs_at = 4'd5;
      default: hs_at = 4'd4;
    endcase
  endfunction

  function automatic logic excluded(input logic [1:0] g, input logic [3:0] hs,
                                    input logic [7:0] n1);
    logic e;
    e = 1'b0;
    if (g != 2'd0) begin
      if (n1 == 8'd1 && (hs == 4'd4 || hs == 4'd5)) e = 1'b1;
      if (g != 2'd1) begin
        if (n1 == 8'd1 && (hs == 4'd6 || hs == 4'd7 || hs == 4'd11)) e = 1'b1;
        if (n1 == 8'd2 && (hs == 4'd4 || hs == 4'd5 || hs == 4'd6 || hs == 4'd7
                           || hs == 4'd9)) e = 1'b1;
        if (g == 2'd2 && n1 == 8'd4 && hs == 4'd4) e = 1'b1;
      end
    end
    excluded = e;
  endfunction

endpackage

FILE: hdl/odrc_if.sv
// ----------------------------------------------------------------------------
// odrc_in_if / odrc_out_if: valid/ready channels
// Input carries the target frequency, output carries the register words.
// ----------------------------------------------------------------------------
interface odrc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] target_freq;
  modport source (output valid, output target_freq, input ready);
  modport sink   (input valid, input target_freq, output ready);
endinterface

interface odrc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  hs_div_code;
  logic [6:0]  n1_code;
  logic [37:0] rfreq;
  modport source (output valid, output status, output hs_div_code, output n1_code,
                  output rfreq, input ready);
  modport sink   (input valid, input status, input hs_div_code, input n1_code,
                  input rfreq, output ready);
endinterface

FILE: hdl/odrc_sdiv.sv
// ----------------------------------------------------------------------------
// odrc_sdiv: bit-serial restoring divider
// One quotient bit per cycle, 72 steps; dividend bits 39..0 enter serially.
// ----------------------------------------------------------------------------
module odrc_sdiv (
  input  logic                clk,
  input  logic                rst,
  input  odrc_pkg::div_req_t  req,
  output odrc_pkg::div_rsp_t  rsp
);
  logic [39:0] sh;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [odrc_pkg::DIVQ_W-1:0] quo;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;
  logic [32:0] rem_sh;

  assign rem_sh = {rem[31:0], sh[39]};
  assign trial  = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        sh   <= req.prod[39:0];
        dvs  <= req.divisor;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        sh  <= {sh[38:0], 1'b0};
        quo <= {quo[odrc_pkg::DIVQ_W-2:0], ~trial[32]};
        rem <= trial[32] ? rem_sh : trial;
        cnt <= cnt + 7'd1;
        if (cnt == 7'(odrc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rsp = '{done: done, quo: quo};
endmodule

FILE: hdl/oscillator_divider_rfreq_calc_top.sv
// ----------------------------------------------------------------------------
// oscillator_divider_rfreq_calc_top: divider search and RFREQ calculation
// Input transfer to result valid: a small change runs 11 shift-add product
// steps and the 72-step serial divide in odrc_sdiv; a large change adds a
// 16-step N0 divide and six divider trials. A zero divisor fails straight
// from the check, a DCO or crystal fail after the product steps.
// One item at a time, and an output stall holds off the next one. Sync
// reset restores register defaults and clears the stored centre, dividers and last RFREQ.
// ----------------------------------------------------------------------------
module oscillator_divider_rfreq_calc_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  odrc_in_if.sink           in_ch,
  odrc_out_if.source        out_ch
);
  // configuration registers
  logic [31:0] crystal_freq;
  logic [12:0] dco_min_mhz, dco_max_mhz;
  logic [1:0]  chip_grade;
  logic [15:0] smooth_ppm;

  // stored state
  logic [31:0] center_freq;
  logic [10:0] total_divider;
  logic [7:0]  slow_divider;
  logic [3:0]  fast_divider;
  logic [37:0] last_rfreq;

  odrc_pkg::state_t state, state_next;
  logic [31:0] f;
  logic        near_hit;
  // serial N0 divide: dividend 16 bits, divisor q (14 bits)
  logic [15:0] n0;        // shift holding dividend then quotient
  logic [13:0] nrem;
  logic [4:0]  cnt;
  logic [2:0]  hs_i;
  logic [10:0] best;
  logic [3:0]  best_hs;
  logic [7:0]  best_n1;
  // N0/HS by repeated subtraction is too long; do restoring divide on n0 by hs
  logic [15:0] hq;
  logic [3:0]  hrem;
  logic [4:0]  hcnt;
  logic [42:0] prod;
  logic [5:0]  pcnt;
  logic [1:0]  ostat;
  logic [2:0]  ohs;
  logic [6:0]  on1;
  logic [37:0] orf;

  odrc_pkg::div_req_t dreq;
  odrc_pkg::div_rsp_t drsp;
  odrc_sdiv u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [13:0] q;
  assign q = f[31:18];

  // small-change compare, a shift-subtract on one side and a wide multiply on the other
  logic [31:0] d;
  logic [35:0] d15;
  logic [31:0] lim;
  logic        near_now;
  assign d   = (f >= center_freq) ? f - center_freq : center_freq - f;
  assign d15 = {d, 4'b0} - {4'b0, d};
  assign lim = {16'b0, center_freq[31:16]} * {16'b0, smooth_ppm};
  assign near_now = smooth_ppm != 16'd0 && {12'b0, d15} <= {16'b0, lim};

  // N0 step
  logic [14:0] ntrial;
  assign ntrial = {nrem, n0[15]} - {1'b0, q};
  // HS step
  logic [4:0]  htrial;
  logic [3:0]  hs_cur;
  assign hs_cur = odrc_pkg::hs_at(hs_i);
  assign htrial = {hrem, hq[15]} - {1'b0, hs_cur};

  logic [16:0] n1_raw;
  logic [7:0]  n1_even;
  logic [11:0] cand;
  assign n1_raw  = {1'b0, hq} + 17'd1;
  assign n1_even = (n1_raw[0] && n1_raw != 17'd1) ? n1_raw[7:0] + 8'd1 : n1_raw[7:0];
  assign cand    = 12'(hs_cur * n1_even);

  // RFREQ rounding and saturation
  logic [odrc_pkg::DIVQ_W-1:0] qq;
  logic [71:0] r;
  logic        dco_bad;
  assign qq = drsp.quo;
  assign r  = {1'b0, qq[71:1]} + {71'b0, qq[0]};
  logic [37:0] rsat;
  assign rsat = (qq[71:63] != 0 || r[71:38] != 0) ? odrc_pkg::RFREQ_MAX : r[37:0];
  logic [12:0] dmax8;
  assign dmax8 = 13'((14'(dco_max_mhz) + 14'd4) >> 3);
  assign dco_bad = (prod[42:24] > {6'b0, dmax8}) || crystal_freq == 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      crystal_freq <= 32'd1917396837;
      dco_min_mhz  <= 13'd4850;
      dco_max_mhz  <= 13'd5670;
      chip_grade   <= 2'd2;
      smooth_ppm   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        odrc_pkg::REG_CRYSTAL: crystal_freq <= cfg_data;
        odrc_pkg::REG_DCO_MIN: dco_min_mhz  <= cfg_data[12:0];
        odrc_pkg::REG_DCO_MAX: dco_max_mhz  <= cfg_data[12:0];
        odrc_pkg::REG_GRADE:   chip_grade   <= cfg_data[1:0];
        odrc_pkg::REG_PPM:     smooth_ppm   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= odrc_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    dreq.start = 1'b0;
    dreq.prod = prod;
    dreq.divisor = crystal_freq;
    case (state)
      odrc_pkg::S_IDLE:   if (in_ch.valid) state_next = odrc_pkg::S_CHECK;
      odrc_pkg::S_CHECK: begin
        if (near_now) state_next = odrc_pkg::S_PROD;
        else if (q == 14'd0) state_next = odrc_pkg::S_OUT;
        else state_next = odrc_pkg::S_N0;
      end
      odrc_pkg::S_N0:     if (cnt == 5'd15) state_next = odrc_pkg::S_HSDIV;
      odrc_pkg::S_HSDIV:  if (hcnt == 5'd15) state_next = odrc_pkg::S_SEARCH;
      odrc_pkg::S_SEARCH: begin
        if (hs_i == 3'd5) state_next = odrc_pkg::S_PROD;
        else state_next = odrc_pkg::S_HSDIV;
      end
      odrc_pkg::S_PROD:   if (pcnt == 6'd10) state_next = odrc_pkg::S_RFREQ;
      odrc_pkg::S_RFREQ: begin
        if (dco_bad || (!near_hit && best_hs == 4'd0)) state_next = odrc_pkg::S_OUT;
        else begin
          dreq.start = 1'b1;
          state_next = odrc_pkg::S_WAIT;
        end
      end
      odrc_pkg::S_WAIT:   if (drsp.done) state_next = odrc_pkg::S_OUT;
      odrc_pkg::S_OUT:    if (out_ch.ready) state_next = odrc_pkg::S_IDLE;
      default: state_next = odrc_pkg::S_IDLE;
    endcase
  end

  assign in_ch.ready = (state == odrc_pkg::S_IDLE);
  assign out_ch.valid = (state == odrc_pkg::S_OUT);
  assign out_ch.status = ostat;
  assign out_ch.hs_div_code = ohs;
  assign out_ch.n1_code = on1;
  assign out_ch.rfreq = orf;

  // total divider used by the product: stored one on small path, best otherwise
  logic [10:0] tdiv;
  assign tdiv = near_hit ? total_divider : best;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_freq <= '0; total_divider <= '0; slow_divider <= '0;
      fast_divider <= '0; last_rfreq <= '0;
    end else begin
      case (state)
        odrc_pkg::S_IDLE: if (in_ch.valid) begin
          f <= in_ch.target_freq;
          cnt <= '0; hcnt <= '0; hs_i <= '0; pcnt <= '0;
          best <= odrc_pkg::DIV_START; best_hs <= '0; best_n1 <= '0;
          ostat <= odrc_pkg::ST_FAIL; ohs <= '0; on1 <= '0; orf <= '0;
        end
        odrc_pkg::S_CHECK: begin
          near_hit <= near_now;
          n0 <= {dco_min_mhz, 3'b0};
          nrem <= '0;
          prod <= '0;
          if (near_now) begin
            ostat <= odrc_pkg::ST_SMALL;
            ohs <= 3'(fast_divider - 4'd4);
            on1 <= 7'(slow_divider - 8'd1);
            orf <= last_rfreq;
          end
        end
        odrc_pkg::S_N0: begin
          nrem <= ntrial[14] ? {nrem[12:0], n0[15]} : ntrial[13:0];
          n0 <= {n0[14:0], ~ntrial[14]};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) begin hq <= {n0[14:0], ~ntrial[14]}; hrem <= '0; end
        end
        odrc_pkg::S_HSDIV: begin
          hrem <= htrial[4] ? {hrem[2:0], hq[15]} : htrial[3:0];
          hq <= {hq[14:0], ~htrial[4]};
          hcnt <= hcnt + 5'd1;
        end
        odrc_pkg::S_SEARCH: begin
          if (n1_raw <= 17'd128 && !odrc_pkg::excluded(chip_grade, hs_cur, n1_even)
              && {1'b0, best} > cand) begin
            best <= cand[10:0]; best_hs <= hs_cur; best_n1 <= n1_even;
          end
          hs_i <= hs_i + 3'd1; hcnt <= '0; hq <= n0; hrem <= '0;
        end
        odrc_pkg::S_PROD: begin
          // shift-add, one divider bit a cycle, MSB first
          prod <= {prod[41:0], 1'b0} + (tdiv[4'(10 - pcnt[3:0])] ? {11'b0, f} : '0);
          pcnt <= pcnt + 6'd1;
        end
        odrc_pkg::S_RFREQ: if (!near_hit && best_hs != 4'd0) begin
          total_divider <= best; slow_divider <= best_n1; fast_divider <= best_hs;
        end
        odrc_pkg::S_WAIT: if (drsp.done) begin
          last_rfreq <= rsat;
          orf <= rsat;
          if (!near_hit) begin
            center_freq <= f;
            ostat <= odrc_pkg::ST_LARGE;
            ohs <= 3'(best_hs - 4'd4);
            on1 <= 7'(best_n1 - 8'd1);
          end
        end
        default: ;
      endcase
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("input and output both open");
  a_start_out: assert property (@(posedge clk) disable iff (rst)
    drsp.done |=> out_ch.valid) else $error("divider result not presented");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.status != 2'd3) else $error("bad status");
endmodule
